// ===== hdl/hpf_pkg.sv =====
// hpf_pkg: shared types and constants for the Hammer forward projection.
// Used by hammer_projection_forward; no dependencies.
package hpf_pkg;

  localparam int IN_W  = 32;        // input word field width, Q2.29
  localparam int OUT_W = IN_W + 4;  // result field width, Q6.29
  localparam int FR_W  = 62;        // fraction bits of c and zz

  localparam logic [63:0] SQRT2_Q62 = 64'd6521908912666391106;
  localparam int          K_SPLIT   = 31;
  localparam logic [31:0] K_HI      = 32'(SQRT2_Q62 >> K_SPLIT);
  localparam logic [30:0] K_LO      = 31'(SQRT2_Q62);
  localparam logic [62:0] ONE_Q62   = 63'(64'd1 << FR_W);

  typedef struct packed {
    logic signed [IN_W-1:0] vec_x;
    logic signed [IN_W-1:0] vec_y;
    logic signed [IN_W-1:0] vec_z;
  } vec_word_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] plane_x;
    logic signed [OUT_W-1:0] plane_y;
    logic signed [OUT_W-1:0] plane_w;
    logic                    degenerate;
  } plane_word_t;

endpackage

// ===== hdl/hpf_delay.sv =====
// hpf_delay: fixed-depth shift line for side data riding beside the math units.
// No package dependency.
module hpf_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    taps[0] <= din;
    for (int i = 1; i < DEPTH; i++) begin
      taps[i] <= taps[i-1];
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

// ===== hdl/hpf_isqrt.sv =====
// hpf_isqrt: pipelined integer square root, one root bit per stage.
// No package dependency.
module hpf_isqrt #(
  parameter int RB = 32
) (
  input  logic            clk,
  input  logic [2*RB-1:0] op,
  output logic [RB-1:0]   root
);

  logic [RB:0]     rem_q  [RB];
  logic [RB-1:0]   root_q [RB];
  logic [2*RB-1:0] op_q   [RB];

  for (genvar i = 0; i < RB; i++) begin : g_stage
    logic [RB:0]     rem_in;
    logic [RB-1:0]   root_in;
    logic [2*RB-1:0] op_in;
    logic [RB+2:0]   remt;
    logic [RB+2:0]   trial;
    logic [RB+2:0]   diff;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign op_in   = op;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign op_in   = op_q[i-1];
    end

    assign remt  = {rem_in, op_in[2*RB-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign diff  = remt - trial;

    always_ff @(posedge clk) begin
      op_q[i] <= op_in << 2;
      if (remt >= trial) begin
        rem_q[i]  <= diff[RB:0];
        root_q[i] <= {root_in[RB-2:0], 1'b1};
      end else begin
        rem_q[i]  <= remt[RB:0];
        root_q[i] <= {root_in[RB-2:0], 1'b0};
      end
    end
  end

  assign root = root_q[RB-1];

endmodule

// ===== hdl/hpf_div.sv =====
// hpf_div: pipelined restoring divider, one quotient bit per stage.
// Needs num >> QB below den; no package dependency.
module hpf_div #(
  parameter int NB = 64,
  parameter int DB = 32,
  parameter int QB = 32
) (
  input  logic          clk,
  input  logic [NB-1:0] num,
  input  logic [DB-1:0] den,
  output logic [QB-1:0] quo
);

  logic [DB-1:0] rem_q [QB];
  logic [QB-1:0] low_q [QB];
  logic [DB-1:0] den_q [QB];
  logic [QB-1:0] quo_q [QB];

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [DB-1:0] rem_in;
    logic [QB-1:0] low_in;
    logic [DB-1:0] den_in;
    logic [QB-1:0] quo_in;
    logic [DB:0]   remt;
    logic [DB:0]   diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in = DB'(num[NB-1:QB]);
      assign low_in = num[QB-1:0];
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign low_in = low_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    assign remt = {rem_in, low_in[QB-1]};
    assign diff = remt - {1'b0, den_in};
    assign ge   = (remt >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      rem_q[i] <= ge ? diff[DB-1:0] : remt[DB-1:0];
      low_q[i] <= low_in << 1;
      den_q[i] <= den_in;
      quo_q[i] <= {quo_in[QB-2:0], ge};
    end
  end

  assign quo = quo_q[QB-1];

endmodule

// ===== hdl/hammer_projection_forward.sv =====
// hammer_projection_forward: Hammer equal-area forward projection of a 3D vector.
// Depends on hpf_pkg, hpf_delay, hpf_isqrt, hpf_div.
//
// Usage:
//   Input channel: drive vec (x, y, z in Q2.29) and pulse start; the word is
//   taken at any edge with start high and busy low. busy is always low, so a
//   new word may enter every cycle.
//   Result channel: done is high for exactly one cycle while plane holds the
//   result (plane_x, plane_y, plane_w in Q6.29 and the degenerate flag).
//   Results come out in input order.
// Throughput: one word per cycle. The chain is bit-serial square roots
// (one root bit per stage) and restoring dividers (one quotient bit per
// stage), all fully pipelined; the divide for c (63 stages) and the square
// root for zz (63 stages) dominate the depth.
// Reset clears the valid line only; words in flight are dropped.
// The receiver has no back-pressure; it must take each result as it appears.
// A zero vector gives zero outputs with degenerate set.
module hammer_projection_forward
  import hpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  vec_word_t   vec,
  output logic        done,
  output plane_word_t plane
);

  localparam int W    = IN_W;
  localparam int YK_W = W + 63;
  localparam int NW   = W + 64;
  localparam int QW   = W + 3;
  localparam int LAT  = 3 + W + 2 + W + 63 + 1 + 63 + 1 + QW + 1;

  logic [LAT-1:0] vpipe;

  assign busy = 1'b0;
  assign done = vpipe[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LAT-2:0], start & ~busy};
    end
  end

  // stage 1: magnitudes and signs ({nz, ny, nx})
  logic [W-1:0] ax, ay, az;
  logic [2:0]   sgn1;
  logic         zero1;

  always_ff @(posedge clk) begin
    ax    <= vec.vec_x[W-1] ? W'(~vec.vec_x + 1'b1) : W'(vec.vec_x);
    ay    <= vec.vec_y[W-1] ? W'(~vec.vec_y + 1'b1) : W'(vec.vec_y);
    az    <= vec.vec_z[W-1] ? W'(~vec.vec_z + 1'b1) : W'(vec.vec_z);
    sgn1  <= {vec.vec_z[W-1], vec.vec_y[W-1], vec.vec_x[W-1]};
    zero1 <= (vec.vec_x == '0) && (vec.vec_y == '0) && (vec.vec_z == '0);
  end

  // stage 2: squares and split product |y| * sqrt2
  logic [2*W-1:0] sqx, sqy, sqz;
  logic [W+31:0]  ykh;
  logic [W+30:0]  ykl;
  logic [W-1:0]   az2;
  logic [2:0]     sgn2;
  logic           zero2;

  always_ff @(posedge clk) begin
    sqx   <= ax * ax;
    sqy   <= ay * ay;
    sqz   <= az * az;
    ykh   <= ay * K_HI;
    ykl   <= ay * K_LO;
    az2   <= az;
    sgn2  <= sgn1;
    zero2 <= zero1;
  end

  // stage 3: h^2, r^2, combined y product
  logic [2*W-1:0]  h2, r2;
  logic [YK_W-1:0] yk3;
  logic [W-1:0]    az3;
  logic [2:0]      sgn3;
  logic            zero3;

  always_ff @(posedge clk) begin
    h2    <= sqx + sqz;
    r2    <= sqx + sqy + sqz;
    yk3   <= {ykh, {K_SPLIT{1'b0}}} + YK_W'(ykl);
    az3   <= az2;
    sgn3  <= sgn2;
    zero3 <= zero2;
  end

  // H and R
  logic [W-1:0]    h4, r4, az4;
  logic [YK_W-1:0] yk4;
  logic [2:0]      sgn4;
  logic            zero4;

  hpf_isqrt #(.RB(W)) u_sqrt_h (.clk(clk), .op(h2), .root(h4));
  hpf_isqrt #(.RB(W)) u_sqrt_r (.clk(clk), .op(r2), .root(r4));

  hpf_delay #(.WIDTH(3 + W + YK_W + 1), .DEPTH(W)) u_dly_a (
    .clk (clk),
    .din ({sgn3, az3, yk3, zero3}),
    .dout({sgn4, az4, yk4, zero4})
  );

  // h - z and h + z, then the two products
  logic [W-1:0]   hp;
  logic [W:0]     hmz, hpz;
  logic [2*W:0]   pm, pp;

  always_ff @(posedge clk) begin
    hp  <= h4;
    hmz <= sgn4[2] ? ({1'b0, h4} + {1'b0, az4}) : ({1'b0, h4} - {1'b0, az4});
    hpz <= sgn4[2] ? ({1'b0, h4} - {1'b0, az4}) : ({1'b0, h4} + {1'b0, az4});
    pm  <= hp * hmz;
    pp  <= hp * hpz;
  end

  // S and Q
  logic [W-1:0]    s5, q5, r5;
  logic [YK_W-1:0] yk5;
  logic [1:0]      sgn5;
  logic            zero5;

  hpf_isqrt #(.RB(W)) u_sqrt_s (.clk(clk), .op(pm[2*W:1]), .root(s5));
  hpf_isqrt #(.RB(W)) u_sqrt_q (.clk(clk), .op(pp[2*W-1:0]), .root(q5));

  hpf_delay #(.WIDTH(W + 2 + YK_W + 1), .DEPTH(W + 2)) u_dly_b (
    .clk (clk),
    .din ({r4, sgn4[1:0], yk4, zero4}),
    .dout({r5, sgn5, yk5, zero5})
  );

  // c = S / R in Q.62
  logic [62:0]     cq;
  logic [W-1:0]    q6, r6;
  logic [YK_W-1:0] yk6;
  logic [1:0]      sgn6;
  logic            zero6;

  hpf_div #(.NB(W + FR_W), .DB(W), .QB(63)) u_div_c (
    .clk(clk),
    .num({s5, {FR_W{1'b0}}}),
    .den(r5),
    .quo(cq)
  );

  hpf_delay #(.WIDTH(2 * W + 2 + YK_W + 1), .DEPTH(63)) u_dly_c (
    .clk (clk),
    .din ({q5, r5, sgn5, yk5, zero5}),
    .dout({q6, r6, sgn6, yk6, zero6})
  );

  logic [62:0]     cc;
  logic [W-1:0]    q7, r7;
  logic [YK_W-1:0] yk7;
  logic [1:0]      sgn7;
  logic            zero7;

  always_ff @(posedge clk) begin
    cc    <= (cq > ONE_Q62) ? ONE_Q62 : cq;
    q7    <= q6;
    r7    <= r6;
    yk7   <= yk6;
    sgn7  <= sgn6;
    zero7 <= zero6;
  end

  // zz = sqrt(1 + c) in Q.62
  logic [62:0]     zz8;
  logic [63:0]     one_c;
  logic [W-1:0]    q8, r8;
  logic [YK_W-1:0] yk8;
  logic [1:0]      sgn8;
  logic            zero8;

  assign one_c = 64'(ONE_Q62) + 64'(cc);

  hpf_isqrt #(.RB(63)) u_sqrt_zz (.clk(clk), .op({one_c, {FR_W{1'b0}}}), .root(zz8));

  hpf_delay #(.WIDTH(2 * W + 2 + YK_W + 1), .DEPTH(63)) u_dly_d (
    .clk (clk),
    .din ({q7, r7, sgn7, yk7, zero7}),
    .dout({q8, r8, sgn8, yk8, zero8})
  );

  // numerators with half-divisor rounding
  logic [NW-1:0] numx, numy;
  logic [62:0]   zz9;
  logic [W-1:0]  r9;
  logic [1:0]    sgn9;
  logic          zero9;

  always_ff @(posedge clk) begin
    numx  <= {1'b0, q8, 63'b0} + NW'(zz8[62:1]);
    numy  <= {1'b0, yk8} + NW'(zz8[62:1]);
    zz9   <= zz8;
    r9    <= r8;
    sgn9  <= sgn8;
    zero9 <= zero8;
  end

  logic [QW-1:0] magx, magy;
  logic [W-1:0]  r10;
  logic [1:0]    sgn10;
  logic          zero10;

  hpf_div #(.NB(NW), .DB(63), .QB(QW)) u_div_x (
    .clk(clk), .num(numx), .den(zz9), .quo(magx)
  );
  hpf_div #(.NB(NW), .DB(63), .QB(QW)) u_div_y (
    .clk(clk), .num(numy), .den(zz9), .quo(magy)
  );

  hpf_delay #(.WIDTH(W + 3), .DEPTH(QW)) u_dly_e (
    .clk (clk),
    .din ({r9, sgn9, zero9}),
    .dout({r10, sgn10, zero10})
  );

  // output word: signs applied, zero vector forced to zeros
  logic [OUT_W-1:0] ext_x, ext_y, ext_r;

  assign ext_x = OUT_W'(magx);
  assign ext_y = OUT_W'(magy);
  assign ext_r = OUT_W'(r10);

  always_ff @(posedge clk) begin
    if (zero10) begin
      plane.plane_x    <= '0;
      plane.plane_y    <= '0;
      plane.plane_w    <= '0;
      plane.degenerate <= 1'b1;
    end else begin
      plane.plane_x    <= sgn10[0] ? (OUT_W'(0) - ext_x) : ext_x;
      plane.plane_y    <= sgn10[1] ? (OUT_W'(0) - ext_y) : ext_y;
      plane.plane_w    <= OUT_W'(0) - ext_r;
      plane.degenerate <= 1'b0;
    end
  end

endmodule
